/* rtl/omv_pkg.sv */
// ----------------------------------------------------------------------------
// omv_pkg: shared types and constants for the online mean and variance block
// Holds the fixed field widths, the controller command and status words.
// ----------------------------------------------------------------------------
`default_nettype none

package omv_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int VAR_W       = 48;
    localparam int CNT_OUT_W   = 13;
    localparam int MEAN_W      = 32;
    localparam int SUM_W       = 64;
    localparam int DIFF_W      = 33;
    localparam int DEV_SHIFT   = 12;
    localparam int DEV_W       = DIFF_W - DEV_SHIFT;
    localparam int PROD_W      = 2 * DEV_W;
    localparam int DIVIDEND_W  = 64;
    localparam int STEP_W      = 7;
    localparam int FRAC_EXTRA  = 16;

    // Number of divider steps for the mean update and for the variance.
    localparam logic [STEP_W-1:0] MEAN_STEPS = STEP_W'(DIFF_W);
    localparam logic [STEP_W-1:0] VAR_STEPS  = STEP_W'(DIVIDEND_W);

    // Fewest samples for which a variance is reported.
    localparam int MIN_VAR_COUNT = 2;

    typedef struct packed {
        logic ld_in;
        logic diff;
        logic ovf_set;
        logic div_m;
        logic mean_upd;
        logic dev;
        logic mul;
        logic acc;
        logic div_v;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic saturated;
        logic last;
        logic div_busy;
        logic var_ok;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

/* rtl/omv_if.sv */
// ----------------------------------------------------------------------------
// omv_if: stream interfaces for samples and results
// Each carries valid, ready and one word of payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface omv_in_if;
    import omv_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;

    modport source (output valid, output sample, output last, input ready);
    modport sink   (input valid, input sample, input last, output ready);
endinterface

interface omv_out_if;
    import omv_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] mean_out;
    logic        [VAR_W-1:0]    variance_out;
    logic        [CNT_OUT_W-1:0] sample_count;
    logic                       overflow;

    modport source (output valid, output mean_out, output variance_out,
                    output sample_count, output overflow, input ready);
    modport sink   (input valid, input mean_out, input variance_out,
                    input sample_count, input overflow, output ready);
endinterface

`default_nettype wire

/* rtl/online_mean_variance.sv */
// ----------------------------------------------------------------------------
// online_mean_variance: running mean and population variance of a sample set
// Samples arrive on i_smp, one signed Q8.8 word each, the final word of a set
// flagged by last. One result word leaves on o_res for every flagged word:
// the mean in Q8.8, the variance M2/n scaled by 2^24, the count and the
// overflow flag, after which the statistics return to zero.
// For each sample the mean update divides the deviation by the running count
// in a shared restoring divider at one bit per cycle, followed by sequencing,
// multiply and accumulate; the next word is taken only once these are done.
// A flagged word adds the 64-bit variance division, or skips it when fewer
// than two samples were taken. A sample arriving at the count limit only
// sets the overflow flag.
// The result sits in an output register; the block takes the next set while
// it waits, and holds in its final step only if the receiver still has not
// taken the previous result. Reset is synchronous and clears the statistics
// and the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module online_mean_variance #(
    parameter int MAX_COUNT = 4096
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    omv_in_if.sink    i_smp,
    omv_out_if.source o_res
);
    import omv_pkg::*;

    localparam logic [CNT_OUT_W-1:0] MAX_CNT_OUT = CNT_OUT_W'(MAX_COUNT);

    t_cmd s_cmd;
    t_sts s_sts;

    omv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_smp.valid),
        .o_in_ready (i_smp.ready),
        .i_sts      (s_sts),
        .o_cmd      (s_cmd)
    );

    omv_dp #(
        .MAX_COUNT (MAX_COUNT)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (s_cmd),
        .o_sts          (s_sts),
        .i_sample       (i_smp.sample),
        .i_last         (i_smp.last),
        .i_out_ready    (o_res.ready),
        .o_out_valid    (o_res.valid),
        .o_mean_out     (o_res.mean_out),
        .o_variance_out (o_res.variance_out),
        .o_sample_count (o_res.sample_count),
        .o_overflow     (o_res.overflow)
    );

    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_smp.valid && i_smp.ready) |=> !i_smp.ready)
        else $error("A second word was taken while the first was still in work.");

    a_div_idle_on_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_cmd.div_m || s_cmd.div_v) |-> !s_sts.div_busy)
        else $error("The divider was started while busy.");

    a_ovf_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.overflow) |-> (o_res.sample_count == MAX_CNT_OUT))
        else $error("Overflow reported with a count below the limit.");

endmodule

`default_nettype wire

/* rtl/omv_div.sv */
// ----------------------------------------------------------------------------
// omv_div: iterative unsigned restoring divider
// One quotient bit per cycle; the dividend is left aligned to the step count.
// ----------------------------------------------------------------------------
`default_nettype none

module omv_div #(
    parameter int DIVISOR_W = 13
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [omv_pkg::DIVIDEND_W-1:0] i_dividend,
    input  wire logic [DIVISOR_W-1:0]           i_divisor,
    input  wire logic [omv_pkg::STEP_W-1:0]     i_steps,
    output      logic                           o_busy,
    output      logic [omv_pkg::DIVIDEND_W-1:0] o_quotient
);
    import omv_pkg::*;

    logic                  r_busy;
    logic [STEP_W-1:0]     r_left;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_div;
    logic [DIVISOR_W:0]    n_rem_sh;
    logic [DIVISOR_W:0]    n_rem_sub;
    logic                  n_ge;

    assign n_rem_sh  = {r_rem, r_quo[DIVIDEND_W-1]};
    assign n_ge      = n_rem_sh >= {1'b0, r_div};
    assign n_rem_sub = n_rem_sh - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_left <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_left <= i_steps;
        end else if (r_busy) begin
            r_left <= r_left - STEP_W'(1);
            if (r_left == STEP_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIVIDEND_W-2:0], n_ge};
            r_rem <= n_ge ? n_rem_sub[DIVISOR_W-1:0] : n_rem_sh[DIVISOR_W-1:0];
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

/* rtl/omv_dp.sv */
// ----------------------------------------------------------------------------
// omv_dp: datapath of the online mean and variance block
// Holds the running statistics, the deviation and product registers, the
// shared divider and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module omv_dp #(
    parameter int MAX_COUNT = 4096
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire omv_pkg::t_cmd                   i_cmd,
    output      omv_pkg::t_sts                   o_sts,
    input  wire logic signed [omv_pkg::SAMPLE_W-1:0] i_sample,
    input  wire logic                            i_last,
    input  wire logic                            i_out_ready,
    output      logic                            o_out_valid,
    output      logic signed [omv_pkg::SAMPLE_W-1:0] o_mean_out,
    output      logic [omv_pkg::VAR_W-1:0]       o_variance_out,
    output      logic [omv_pkg::CNT_OUT_W-1:0]   o_sample_count,
    output      logic                            o_overflow
);
    import omv_pkg::*;

    localparam int CW = $clog2(MAX_COUNT + 1);

    logic signed [SAMPLE_W-1:0] r_sample;
    logic                       r_last;
    logic [CW-1:0]              r_count;
    logic signed [MEAN_W-1:0]   r_mean;
    logic [SUM_W-1:0]           r_sum;
    logic                       r_ovf;
    logic signed [DIFF_W-1:0]   r_d1;
    logic signed [DIFF_W-1:0]   r_d2;
    logic signed [PROD_W-1:0]   r_prod;

    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_mean_out;
    logic [VAR_W-1:0]           r_var_out;
    logic [CNT_OUT_W-1:0]       r_cnt_out;
    logic                       r_ovf_out;

    logic signed [DIFF_W-1:0]   n_scaled;
    logic signed [DIFF_W-1:0]   n_d1;
    logic signed [DIFF_W-1:0]   n_d2;
    logic [DIFF_W-1:0]          n_mag;
    logic [DIVIDEND_W-1:0]      n_dividend;
    logic [CW-1:0]              n_divisor;
    logic [STEP_W-1:0]          n_steps;
    logic [DIFF_W:0]            n_q;
    logic [DIFF_W:0]            n_mean_wide;
    logic signed [DEV_W-1:0]    n_dev1;
    logic signed [DEV_W-1:0]    n_dev2;
    logic [DIFF_W-1:0]          n_mean_rnd;
    logic [CW+CNT_OUT_W-1:0]    n_cnt_wide;
    logic                       n_var_ok;
    logic                       n_div_busy;
    logic [DIVIDEND_W-1:0]      n_quotient;

    assign n_scaled = {r_sample[SAMPLE_W-1], r_sample, {FRAC_EXTRA{1'b0}}};
    assign n_d1     = n_scaled - {r_mean[MEAN_W-1], r_mean};
    assign n_d2     = n_scaled - {r_mean[MEAN_W-1], r_mean};
    assign n_mag    = r_d1[DIFF_W-1] ? -r_d1 : r_d1;

    always_comb begin
        if (i_cmd.div_v) begin
            n_dividend = r_sum;
            n_divisor  = r_count;
            n_steps    = VAR_STEPS;
        end else begin
            n_dividend = {n_mag, {(DIVIDEND_W-DIFF_W){1'b0}}};
            n_divisor  = r_count + CW'(1);
            n_steps    = MEAN_STEPS;
        end
    end

    omv_div #(
        .DIVISOR_W (CW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_m | i_cmd.div_v),
        .i_dividend (n_dividend),
        .i_divisor  (n_divisor),
        .i_steps    (n_steps),
        .o_busy     (n_div_busy),
        .o_quotient (n_quotient)
    );

    assign n_q = r_d1[DIFF_W-1] ? -{1'b0, n_quotient[DIFF_W-1:0]}
                                :  {1'b0, n_quotient[DIFF_W-1:0]};
    assign n_mean_wide = {{2{r_mean[MEAN_W-1]}}, r_mean} + n_q;

    assign n_dev1 = DEV_W'(r_d1 >>> DEV_SHIFT);
    assign n_dev2 = DEV_W'(r_d2 >>> DEV_SHIFT);

    assign n_mean_rnd = {r_mean[MEAN_W-1], r_mean}
                      + (r_mean[MEAN_W-1] ? DIFF_W'((1 << FRAC_EXTRA) - 1) : '0);
    assign n_cnt_wide = {{CNT_OUT_W{1'b0}}, r_count};
    assign n_var_ok   = r_count >= CW'(MIN_VAR_COUNT);

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_in) begin
            r_sample <= i_sample;
            r_last   <= i_last;
        end
        if (i_cmd.diff) begin
            r_d1 <= n_d1;
        end
        if (i_cmd.dev) begin
            r_d2 <= n_d2;
        end
        if (i_cmd.mul) begin
            r_prod <= n_dev1 * n_dev2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_mean  <= '0;
            r_sum   <= '0;
            r_ovf   <= 1'b0;
        end else if (i_cmd.emit && o_sts.out_free) begin
            r_count <= '0;
            r_mean  <= '0;
            r_sum   <= '0;
            r_ovf   <= 1'b0;
        end else begin
            if (i_cmd.ovf_set) begin
                r_ovf <= 1'b1;
            end
            if (i_cmd.mean_upd) begin
                r_mean  <= n_mean_wide[MEAN_W-1:0];
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.acc && !r_prod[PROD_W-1] && (r_prod != '0)) begin
                r_sum <= r_sum + SUM_W'(unsigned'(r_prod));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit && o_sts.out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit && o_sts.out_free) begin
            r_mean_out <= n_mean_rnd[MEAN_W-1:FRAC_EXTRA];
            r_var_out  <= n_var_ok ? n_quotient[VAR_W-1:0] : '0;
            r_cnt_out  <= n_cnt_wide[CNT_OUT_W-1:0];
            r_ovf_out  <= r_ovf;
        end
    end

    assign o_sts.saturated = r_count >= CW'(MAX_COUNT);
    assign o_sts.last      = r_last;
    assign o_sts.div_busy  = n_div_busy;
    assign o_sts.var_ok    = n_var_ok;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid    = r_out_valid;
    assign o_mean_out     = r_mean_out;
    assign o_variance_out = r_var_out;
    assign o_sample_count = r_cnt_out;
    assign o_overflow     = r_ovf_out;

endmodule

`default_nettype wire

/* rtl/omv_ctrl.sv */
// ----------------------------------------------------------------------------
// omv_ctrl: sequencer of the online mean and variance block
// Steps each sample through difference, division, mean, deviation, product
// and accumulation, then the variance division and the result on a last word.
// ----------------------------------------------------------------------------
`default_nettype none

module omv_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output      logic          o_in_ready,
    input  wire omv_pkg::t_sts i_sts,
    output      omv_pkg::t_cmd o_cmd
);
    import omv_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_DIFF   = 11'b00000000010,
        S_DIV_M  = 11'b00000000100,
        S_WAIT_M = 11'b00000001000,
        S_MEAN   = 11'b00000010000,
        S_DEV    = 11'b00000100000,
        S_MUL    = 11'b00001000000,
        S_ACC    = 11'b00010000000,
        S_DIV_V  = 11'b00100000000,
        S_WAIT_V = 11'b01000000000,
        S_EMIT   = 11'b10000000000
    } t_state;

    t_state r_state;
    t_state n_state;
    t_state n_after;

    always_comb begin
        if (!i_sts.last) begin
            n_after = S_IDLE;
        end else if (i_sts.var_ok) begin
            n_after = S_DIV_V;
        end else begin
            n_after = S_EMIT;
        end
    end

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                o_cmd.ld_in = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_DIFF;
                end
            end
            S_DIFF: begin
                o_cmd.diff = 1'b1;
                if (i_sts.saturated) begin
                    o_cmd.ovf_set = 1'b1;
                    n_state       = n_after;
                end else begin
                    n_state = S_DIV_M;
                end
            end
            S_DIV_M: begin
                o_cmd.div_m = 1'b1;
                n_state     = S_WAIT_M;
            end
            S_WAIT_M: begin
                if (!i_sts.div_busy) begin
                    n_state = S_MEAN;
                end
            end
            S_MEAN: begin
                o_cmd.mean_upd = 1'b1;
                n_state        = S_DEV;
            end
            S_DEV: begin
                o_cmd.dev = 1'b1;
                n_state   = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = n_after;
            end
            S_DIV_V: begin
                o_cmd.div_v = 1'b1;
                n_state     = S_WAIT_V;
            end
            S_WAIT_V: begin
                if (!i_sts.div_busy) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

`default_nettype wire
